@@ hw/rtl/vtbp_pkg.sv @@
// Shared types and constants for the video timing and background pixel block.
package vtbp_pkg;

    localparam int VRAM_BYTES = 16384;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_POLL  = 2'd3;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [15:0] STATUS_ADDR = 16'h2002;
    localparam logic [15:0] DATA_ADDR   = 16'h2007;

    localparam logic [8:0] LINE_FIRST    = 9'h1ff;
    localparam logic [8:0] LINE_LAST     = 9'd260;
    localparam logic [8:0] DOT_LAST      = 9'd340;
    localparam logic [8:0] VISIBLE_LINES = 9'd240;
    localparam logic [8:0] VBLANK_LINE   = 9'd241;
    localparam logic [8:0] DOT_PIX_END   = 9'd256;

    localparam logic [9:0] PALETTE_PREFIX = 10'h3f0;
    localparam logic [3:0] ATTR_PREFIX    = 4'hf;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_PIXEL = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [VRAM_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic [7:0]         read_data;
        logic               nmi;
        logic [7:0]         x;
        logic [7:0]         y;
        logic [1:0]         nt_sel;
        logic               pt_hi;
    } entry_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

@@ hw/rtl/vtbp_req_if.sv @@
// Request channel: one input word per handshake.
interface vtbp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;

    modport source (output valid, action, bus_addr, write_data, input ready);
    modport sink   (input valid, action, bus_addr, write_data, output ready);
endinterface

@@ hw/rtl/vtbp_rsp_if.sv @@
// Response channel: one result word per handshake.
interface vtbp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       nmi_flag;
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] pixel_color;

    modport source (output valid, read_data, nmi_flag, pixel_valid, pixel_x, pixel_y,
                    pixel_color, input ready);
    modport sink   (input valid, read_data, nmi_flag, pixel_valid, pixel_x, pixel_y,
                    pixel_color, output ready);
endinterface

@@ hw/rtl/vtbp_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module vtbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end
endmodule

@@ hw/rtl/vtbp_fifo.sv @@
// Short queue of decoded words between front and back.
module vtbp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vtbp_pkg::entry_t din,
    output logic            full,
    input  logic            pop,
    output vtbp_pkg::entry_t dout,
    output logic            empty
);
    import vtbp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t         mem_reg [DEPTH];
    logic [PW-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop) else $error("pop from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count slip");
`endif
endmodule

@@ hw/rtl/vtbp_front.sv @@
// Front: timing counters, bus registers and decode of each word into the queue.
module vtbp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    vtbp_req_if.sink               req,
    input  vtbp_pkg::back_status_t status,
    input  logic                   queue_full,
    output logic                   push,
    output vtbp_pkg::entry_t       entry
);
    import vtbp_pkg::*;

    logic [8:0]  line_reg, line_next;
    logic [8:0]  dot_reg, dot_next;
    logic        vblank_reg, vblank_next;
    logic        nmi_reg, nmi_next;
    logic        latch_reg, latch_next;
    logic [15:0] pointer_reg, pointer_next;
    logic [7:0]  control_reg, control_next;
    logic [15:0] step;
    logic        accept;

    assign req.ready = !status.clearing && !queue_full;
    assign accept    = req.valid && req.ready;
    assign push      = accept;
    assign step      = control_reg[2] ? 16'd32 : 16'd1;

    always_comb
    begin
        line_next    = line_reg;
        dot_next     = dot_reg;
        vblank_next  = vblank_reg;
        nmi_next     = nmi_reg;
        latch_next   = latch_reg;
        pointer_next = pointer_reg;
        control_next = control_reg;
        entry        = '0;
        entry.kind   = KIND_PLAIN;
        if (accept)
        begin
            case (req.action)
                ACT_TICK:
                begin
                    if (line_reg == LINE_FIRST && dot_reg == 9'd1)
                    begin
                        vblank_next = 1'b0;
                    end
                    if (line_reg < VISIBLE_LINES && dot_reg != 9'd0 && dot_reg < DOT_PIX_END)
                    begin
                        entry.kind   = KIND_PIXEL;
                        entry.x      = dot_reg[7:0];
                        entry.y      = line_reg[7:0];
                        entry.nt_sel = control_reg[1:0];
                        entry.pt_hi  = control_reg[4];
                    end
                    if (line_reg == VBLANK_LINE && dot_reg == 9'd1)
                    begin
                        if (control_reg[7])
                        begin
                            nmi_next = 1'b1;
                        end
                        vblank_next = 1'b1;
                    end
                    if (dot_reg >= DOT_LAST)
                    begin
                        dot_next  = '0;
                        line_next = (line_reg == LINE_LAST) ? LINE_FIRST : line_reg + 1'b1;
                    end
                    else
                    begin
                        dot_next = dot_reg + 1'b1;
                    end
                end
                ACT_WRITE:
                begin
                    case (req.bus_addr[2:0])
                        REG_CTRL:   control_next = req.write_data;
                        REG_SCROLL: latch_next = !latch_reg;
                        REG_ADDR:
                        begin
                            if (latch_reg)
                            begin
                                pointer_next = {2'b00, req.write_data[5:0], pointer_reg[7:0]};
                            end
                            else
                            begin
                                pointer_next = {pointer_reg[15:8], req.write_data};
                            end
                            latch_next = !latch_reg;
                        end
                        REG_DATA:
                        begin
                            if (pointer_reg[15:VRAM_AW] == '0)
                            begin
                                entry.kind   = KIND_WRITE;
                                entry.waddr  = pointer_reg[VRAM_AW-1:0];
                                entry.wdata  = req.write_data;
                                pointer_next = pointer_reg + step;
                            end
                        end
                        default: ;
                    endcase
                end
                ACT_READ:
                begin
                    if (req.bus_addr == STATUS_ADDR)
                    begin
                        entry.read_data = {vblank_reg, 7'b0};
                        vblank_next     = 1'b0;
                        latch_next      = 1'b1;
                    end
                    else if (req.bus_addr == DATA_ADDR)
                    begin
                        pointer_next = pointer_reg + step;
                    end
                end
                ACT_POLL:
                begin
                    entry.nmi = nmi_reg;
                    nmi_next  = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg    <= LINE_FIRST;
            dot_reg     <= '0;
            vblank_reg  <= 1'b0;
            nmi_reg     <= 1'b0;
            latch_reg   <= 1'b1;
            pointer_reg <= '0;
            control_reg <= '0;
        end
        else
        begin
            line_reg    <= line_next;
            dot_reg     <= dot_next;
            vblank_reg  <= vblank_next;
            nmi_reg     <= nmi_next;
            latch_reg   <= latch_next;
            pointer_reg <= pointer_next;
            control_reg <= control_next;
        end
    end
endmodule

@@ hw/rtl/vtbp_back.sv @@
// Back: memory clear, memory writes and the background fetch sequence.
module vtbp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vtbp_pkg::entry_t       head,
    input  logic                   empty,
    output logic                   pop,
    output vtbp_pkg::back_status_t status,
    vtbp_rsp_if.source             rsp
);
    import vtbp_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_PAT   = 5'b00100,
        S_PAL   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [VRAM_AW-1:0] clr_reg, clr_next;
    logic [7:0]         x_reg, x_next, y_reg, y_next, attr_reg, attr_next;
    logic               pt_reg, pt_next;
    logic [VRAM_AW-1:0] pal_reg, pal_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         rd_reg, rd_next;
    logic               nmi_reg, nmi_next;
    logic               pv_reg, pv_next;
    logic [7:0]         px_reg, px_next, py_reg, py_next, pc_reg, pc_next;

    logic               we;
    logic [VRAM_AW-1:0] waddr, raddr0, raddr1;
    logic [7:0]         wdata, rdata0, rdata1;
    logic               out_free, load;
    logic [2:0]         shift, bsel;
    logic [1:0]         pal;
    logic [7:0]         attr_sh;

    vtbp_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    assign status.clearing = (state_reg == S_CLEAR);
    assign out_free        = !out_valid_reg || rsp.ready;

    // attribute quadrant and pixel bit within the pattern row
    assign shift   = {y_reg[3], x_reg[3], 1'b0};
    assign attr_sh = attr_reg >> shift;
    assign pal     = attr_sh[1:0];
    assign bsel    = ~x_reg[2:0];

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        pt_next    = pt_reg;
        attr_next  = attr_reg;
        pal_next   = pal_reg;
        pop        = 1'b0;
        we         = 1'b0;
        waddr      = head.waddr;
        wdata      = head.wdata;
        raddr0     = pal_reg;
        raddr1     = pal_reg;
        load       = 1'b0;
        rd_next    = rd_reg;
        nmi_next   = nmi_reg;
        pv_next    = pv_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pc_next    = pc_reg;
        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!empty)
                begin
                    if (head.kind == KIND_PIXEL)
                    begin
                        pop        = 1'b1;
                        raddr0     = {2'b10, head.nt_sel, head.y[7:3], head.x[7:3]};
                        raddr1     = {2'b10, head.nt_sel, ATTR_PREFIX, head.y[7:5],
                                      head.x[7:5]};
                        x_next     = head.x;
                        y_next     = head.y;
                        pt_next    = head.pt_hi;
                        state_next = S_PAT;
                    end
                    else if (out_free)
                    begin
                        pop      = 1'b1;
                        load     = 1'b1;
                        we       = (head.kind == KIND_WRITE);
                        rd_next  = head.read_data;
                        nmi_next = head.nmi;
                        pv_next  = 1'b0;
                        px_next  = '0;
                        py_next  = '0;
                        pc_next  = '0;
                    end
                end
            end
            S_PAT:
            begin
                raddr0     = {1'b0, pt_reg, rdata0, 1'b0, y_reg[2:0]};
                raddr1     = {1'b0, pt_reg, rdata0, 1'b1, y_reg[2:0]};
                attr_next  = rdata1;
                state_next = S_PAL;
            end
            S_PAL:
            begin
                pal_next   = {PALETTE_PREFIX, pal, rdata1[bsel], rdata0[bsel]};
                raddr0     = pal_next;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // palette address is reissued so the read data holds during a stall
                if (out_free)
                begin
                    load       = 1'b1;
                    rd_next    = '0;
                    nmi_next   = 1'b0;
                    pv_next    = 1'b1;
                    px_next    = x_reg;
                    py_next    = y_reg;
                    pc_next    = rdata0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        out_valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        pt_reg   <= pt_next;
        attr_reg <= attr_next;
        pal_reg  <= pal_next;
        rd_reg   <= rd_next;
        nmi_reg  <= nmi_next;
        pv_reg   <= pv_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pc_reg   <= pc_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = rd_reg;
    assign rsp.nmi_flag    = nmi_reg;
    assign rsp.pixel_valid = pv_reg;
    assign rsp.pixel_x     = px_reg;
    assign rsp.pixel_y     = py_reg;
    assign rsp.pixel_color = pc_reg;

`ifndef SYNTHESIS
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !out_valid_reg && !pop) else $error("activity during clear");
    a_pixel_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pv_reg |-> py_reg < 8'd240 && px_reg != 8'd0)
        else $error("pixel outside visible area");
    a_fetch_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PAT |=> state_reg == S_PAL) else $error("fetch sequence broken");
`endif
endmodule

@@ hw/rtl/video_timing_and_background_pixel.sv @@
// Video timing and background pixel renderer behind eight bus registers, with a 16 KB
// video memory. After reset the memory is zeroed, and no word is accepted while that
// runs. Every accepted word gives exactly one result word, in order. Bus writes, reads,
// polls and non-pixel ticks are completed in the idle state of the back end; a pixel tick
// goes through the dependent video memory reads (name and attribute, then both pattern
// planes, then palette) on the two-read-port memory. The request side keeps accepting into a
// queue of QUEUE_DEPTH words while the back end works or the result waits.
module video_timing_and_background_pixel #(
    parameter int QUEUE_DEPTH = 4
) (
    input logic        clk,
    input logic        rst_n,
    vtbp_req_if.sink   req,
    vtbp_rsp_if.source rsp
);
    import vtbp_pkg::*;

    entry_t       push_entry, head_entry;
    logic         push, pop, full, empty;
    back_status_t status;

    vtbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .status     (status),
        .queue_full (full),
        .push       (push),
        .entry      (push_entry)
    );

    vtbp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_entry),
        .full  (full),
        .pop   (pop),
        .dout  (head_entry),
        .empty (empty)
    );

    vtbp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head_entry),
        .empty  (empty),
        .pop    (pop),
        .status (status),
        .rsp    (rsp)
    );
endmodule

@@ tb/video_timing_and_background_pixel_tb.sv @@
// Self-checking testbench for the video timing and background pixel block.
`timescale 1ns / 1ps

module video_timing_and_background_pixel_tb;
    import vtbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int PIXEL_RUN      = 40;

    typedef struct packed {
        logic [7:0] rd;
        logic       nmi;
        logic       pv;
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] pc;
    } vid_res_t;

    typedef struct {
        logic [1:0]  act;
        logic [15:0] addr;
        logic [7:0]  data;
        bit          typed;
        logic [7:0]  rd;
        logic        nmi;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    vtbp_req_if req();
    vtbp_rsp_if rsp();

    video_timing_and_background_pixel DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #10 clk = ~clk;

    // predictor state
    logic [7:0]  vmem [VRAM_BYTES];
    int          line_pos;
    int          dot_pos;
    bit          vblank;
    bit          nmi_req;
    bit          latch_hi;
    logic [15:0] vptr;
    logic [7:0]  ctrl;

    vid_res_t    expected_q[$];
    int          errors;
    int          burst_left;
    int          idle_cycles;
    int          cyc_cnt;
    int          stall_mode;
    int          n_words;
    int          n_pix;
    int          n_vbl_seen;
    int          n_nmi_seen;

    function automatic logic [7:0] vread(int a);
        return vmem[a & (VRAM_BYTES - 1)];
    endfunction

    function automatic logic [7:0] bg_pixel(int x, int y);
        int nt;
        int pt;
        int tile;
        int lo;
        int hi;
        int attr;
        int sh;
        int pal;
        int b;
        int idx;
        nt   = 32'h2000 + 32'h400 * int'(ctrl[1:0]);
        pt   = ctrl[4] ? 32'h1000 : 0;
        tile = vread(nt + (y >> 3) * 32 + (x >> 3));
        lo   = vread(pt + tile * 16 + (y & 7));
        hi   = vread(pt + tile * 16 + 8 + (y & 7));
        attr = vread(nt + 32'h3c0 + (y >> 5) * 8 + (x >> 5));
        sh   = (((x & 15) >> 3) << 1) + (((y & 15) >> 3) << 2);
        pal  = (attr >> sh) & 3;
        b    = 7 - (x & 7);
        idx  = (pal << 2) | (((hi >> b) & 1) << 1) | ((lo >> b) & 1);
        return vread(32'h3f00 + idx);
    endfunction

    task automatic model_step(input logic [1:0] act, input logic [15:0] addr,
                              input logic [7:0] data, output vid_res_t r);
        logic [15:0] stepv;
        begin
            r = '0;
            stepv = ctrl[2] ? 16'd32 : 16'd1;
            case (act)
                ACT_TICK:
                begin
                    if (line_pos == -1 && dot_pos == 1)
                        vblank = 1'b0;
                    if (line_pos >= 0 && line_pos < 240 && dot_pos >= 1 && dot_pos < 256)
                    begin
                        r.pv = 1'b1;
                        r.px = dot_pos[7:0];
                        r.py = line_pos[7:0];
                        r.pc = bg_pixel(dot_pos, line_pos);
                        n_pix++;
                    end
                    if (line_pos == 241 && dot_pos == 1)
                    begin
                        if (ctrl[7])
                            nmi_req = 1'b1;
                        vblank = 1'b1;
                    end
                    if (dot_pos >= 340)
                    begin
                        dot_pos = 0;
                        line_pos = (line_pos >= 260) ? -1 : line_pos + 1;
                    end
                    else
                        dot_pos++;
                end
                ACT_WRITE:
                    case (addr[2:0])
                        REG_CTRL:   ctrl = data;
                        REG_SCROLL: latch_hi = !latch_hi;
                        REG_ADDR:
                        begin
                            if (latch_hi)
                                vptr = {2'b00, data[5:0], vptr[7:0]};
                            else
                                vptr[7:0] = data;
                            latch_hi = !latch_hi;
                        end
                        REG_DATA:
                            if (vptr < VRAM_BYTES)
                            begin
                                vmem[vptr[VRAM_AW-1:0]] = data;
                                vptr = vptr + stepv;
                            end
                        default: ;
                    endcase
                ACT_READ:
                    if (addr == STATUS_ADDR)
                    begin
                        r.rd = {vblank, 7'd0};
                        if (vblank)
                            n_vbl_seen++;
                        vblank = 1'b0;
                        latch_hi = 1'b1;
                    end
                    else if (addr == DATA_ADDR)
                        vptr = vptr + stepv;
                default:
                begin
                    r.nmi = nmi_req;
                    if (nmi_req)
                        n_nmi_seen++;
                    nmi_req = 1'b0;
                end
            endcase
        end
    endtask

    // sender: bursts of random length, random gaps between them
    task automatic issue_word(input logic [1:0] act, input logic [15:0] addr,
                              input logic [7:0] data, input bit typed = 1'b0,
                              input logic [7:0] trd = 8'h00, input logic tnmi = 1'b0);
        int gap;
        vid_res_t r;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                if (gap > 0)
                begin
                    req.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            req.valid      <= 1'b1;
            req.action     <= act;
            req.bus_addr   <= addr;
            req.write_data <= data;
            @(posedge clk);
            while (!req.ready)
                @(posedge clk);
            model_step(act, addr, data, r);
            if (typed)
            begin
                r = '0;
                r.rd = trd;
                r.nmi = tnmi;
            end
            expected_q.push_back(r);
            n_words++;
        end
    endtask

    task automatic set_pointer(input logic [13:0] a);
        begin
            issue_word(ACT_READ, STATUS_ADDR, 8'($urandom));
            issue_word(ACT_WRITE, 16'h2006, {2'($urandom), a[13:8]});
            issue_word(ACT_WRITE, 16'h2006, a[7:0]);
        end
    endtask

    task automatic load_bytes(input logic [13:0] base, input int n);
        begin
            set_pointer(base);
            repeat (n)
                issue_word(ACT_WRITE, 16'h2007, 8'($urandom));
        end
    endtask

    task automatic random_word();
        int k;
        logic [15:0] a;
        begin
            k = $urandom_range(0, 11);
            case (k)
                0, 1:
                begin
                    // well-formed load into a table region or at a random address
                    case ($urandom_range(0, 3))
                        0: a = 16'($urandom_range(16'h2000, 16'h2fff));
                        1: a = 16'($urandom_range(0, 16'h1fff));
                        2: a = 16'($urandom_range(16'h3f00, 16'h3fff));
                        default: a = 16'($urandom);
                    endcase
                    load_bytes(a[13:0], $urandom_range(1, 8));
                end
                2: issue_word(ACT_WRITE, {13'($urandom), REG_CTRL}, 8'($urandom));
                3, 4: repeat ($urandom_range(1, 20)) issue_word(ACT_TICK, 16'($urandom),
                                                               8'($urandom));
                5: issue_word(ACT_READ, STATUS_ADDR, 8'($urandom));
                6: issue_word(ACT_POLL, 16'($urandom), 8'($urandom));
                7: issue_word(ACT_READ, DATA_ADDR, 8'($urandom));
                8: issue_word(ACT_WRITE, 16'($urandom), 8'($urandom));
                9: issue_word(ACT_READ, 16'($urandom), 8'($urandom));
                10: issue_word(ACT_WRITE, {13'($urandom), REG_SCROLL}, 8'($urandom));
                default: issue_word(2'($urandom), 16'($urandom), 8'($urandom));
            endcase
        end
    endtask

    dir_row_t dir_rows [22] = '{
        '{ACT_READ,  STATUS_ADDR, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_POLL,  16'h0000,    8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_READ,  16'hffff,    8'hff, 1'b1, 8'h00, 1'b0},
        '{ACT_READ,  16'h0000,    8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2000,    8'hff, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2000,    8'h00, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2005,    8'haa, 1'b0, 8'h00, 1'b0},
        '{ACT_READ,  STATUS_ADDR, 8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2006,    8'hff, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2006,    8'hff, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2007,    8'hff, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2007,    8'h55, 1'b0, 8'h00, 1'b0},
        '{ACT_READ,  DATA_ADDR,   8'h00, 1'b1, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2001,    8'h5a, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2002,    8'ha5, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2003,    8'h0f, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h2004,    8'hf0, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'hffff,    8'h00, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'h0006,    8'h00, 1'b0, 8'h00, 1'b0},
        '{ACT_WRITE, 16'hfffe,    8'h00, 1'b0, 8'h00, 1'b0},
        '{ACT_TICK,  16'hffff,    8'hff, 1'b1, 8'h00, 1'b0},
        '{ACT_POLL,  16'hffff,    8'hff, 1'b1, 8'h00, 1'b0}
    };

    // receiver stall pattern, result check and watchdog
    always @(posedge clk)
    begin
        vid_res_t e;
        cyc_cnt++;
        if (cyc_cnt % 256 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            2: rsp.ready <= ($urandom_range(0, 3) == 0);
            default: rsp.ready <= (cyc_cnt % 5 != 0);
        endcase
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (rsp.read_data !== e.rd)
                begin
                    $error("read_data exp %h got %h", e.rd, rsp.read_data);
                    errors++;
                end
                if (rsp.nmi_flag !== e.nmi)
                begin
                    $error("nmi_flag exp %h got %h", e.nmi, rsp.nmi_flag);
                    errors++;
                end
                if (rsp.pixel_valid !== e.pv)
                begin
                    $error("pixel_valid exp %h got %h", e.pv, rsp.pixel_valid);
                    errors++;
                end
                if (rsp.pixel_x !== e.px)
                begin
                    $error("pixel_x exp %h got %h", e.px, rsp.pixel_x);
                    errors++;
                end
                if (rsp.pixel_y !== e.py)
                begin
                    $error("pixel_y exp %h got %h", e.py, rsp.pixel_y);
                    errors++;
                end
                if (rsp.pixel_color !== e.pc)
                begin
                    $error("pixel_color exp %h got %h", e.pc, rsp.pixel_color);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int i;
        int n_rand;
        rsp.ready      = 1'b0;
        req.valid      = 1'b0;
        req.action     = ACT_TICK;
        req.bus_addr   = '0;
        req.write_data = '0;
        errors = 0;
        burst_left = 0;
        idle_cycles = 0;
        cyc_cnt = 0;
        stall_mode = 0;
        n_words = 0;
        n_pix = 0;
        n_vbl_seen = 0;
        n_nmi_seen = 0;
        for (i = 0; i < VRAM_BYTES; i++)
            vmem[i] = 8'h00;
        line_pos = -1;
        dot_pos  = 0;
        vblank   = 1'b0;
        nmi_req  = 1'b0;
        latch_hi = 1'b1;
        vptr     = '0;
        ctrl     = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[j])
            issue_word(dir_rows[j].act, dir_rows[j].addr, dir_rows[j].data,
                       dir_rows[j].typed, dir_rows[j].rd, dir_rows[j].nmi);

        // step by 32 from 0x3fe0 to 0x4000, then a data write there is dropped
        issue_word(ACT_WRITE, 16'h2000, 8'h04);
        set_pointer(14'h3fe0);
        issue_word(ACT_READ, DATA_ADDR, 8'($urandom));
        issue_word(ACT_WRITE, 16'h2007, 8'($urandom));
        issue_word(ACT_WRITE, 16'h2000, 8'h00);

        n_rand = 0;
        while (n_rand < 20)
        begin
            random_word();
            n_rand++;
        end

        // run the counters onto the first visible line
        while (line_pos < 0)
            issue_word(ACT_TICK, 16'($urandom), 8'($urandom));
        for (i = 0; i < PIXEL_RUN; i++)
            issue_word(ACT_TICK, 16'($urandom), 8'($urandom));

        repeat (15)
            random_word();
        req.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("%0d words checked into the first visible line: %0d pixels, %0d vblank reads",
                 n_words, n_pix, n_vbl_seen);
        $display("%0d nmi polls hit, register decode and out-of-range writes covered",
                 n_nmi_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
